// ===== rtl/jacobi_linear_solver_defines.svh =====
// Assertion macros shared by the solver RTL
`ifndef JACOBI_LINEAR_SOLVER_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_DEFINES_SVH
// clocked implication check, disabled while the active-low reset is asserted
`define JLS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication check
`define JLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/jls_pkg.sv =====
// Shared types and constants of the Jacobi solver
package jls_pkg;
    localparam int N_ROWS     = 4;
    localparam int N_COLS     = N_ROWS + 1;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ROW_W      = 2;
    localparam int COL_W      = 3;
    localparam int ACC_W      = 2 * DATA_WIDTH + 4;
    localparam int NUM_W      = ACC_W + 1;
    localparam int DIV_W      = NUM_W + FRAC_BITS;
    localparam int DCNT_W     = $clog2(DIV_W + 1);

    localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
    localparam logic [1:0] OP_LOAD_GUESS = 2'd1;
    localparam logic [1:0] OP_START      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_DIV_START, ST_DIV_WAIT, ST_COMMIT, ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr_acc;
        logic mac;
        logic div_start;
        logic store_next;
        logic commit;
        logic clr_dz;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } dp_stat_t;
endpackage

// ===== rtl/jacobi_linear_solver.sv =====
// Jacobi iterative solver top level
// Usage:
//   s_axis: tdata holds op, row, col, value. Op 0 loads a coefficient (col 4 is b),
//   op 1 loads a guess element, op 2 starts iteration_count sweeps. Loads give
//   no item. A start item gives four result items on m_axis, rows 0..3, tlast on
//   row 3, tuser the divide-by-zero flag of the solve.
//   Each row of a sweep runs N_ROWS multiply steps, drains the product pipeline,
//   starts the divider, waits for the bit-serial restoring divider and stores
//   the quotient; each sweep ends with a commit of the new guess. A zero
//   diagonal skips the divider loop.
//   s_tready is low from a start item until the last result is taken.
//   A stalled receiver holds the current result; the solver waits.
//   Reset clears the guess to zero and sets iteration_count to 30; the coefficient
//   store is undefined until written.
//   cfg_we writes iteration_count; write only while the block is idle (not enforced).
module jacobi_linear_solver import jls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[1:0], row[3:2], col[6:4], value[38:7], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // row_index[1:0], solution[33:2], zero
    output logic        m_tlast,
    output logic        m_tuser    // divide_by_zero
);
    logic [7:0] iter_reg;
    logic [1:0] op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic signed [DATA_WIDTH-1:0] value;
    logic acc, idle;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [ROW_W-1:0] j_idx, k_idx, emit_row;
    logic signed [DATA_WIDTH-1:0] rd_value;
    logic dz_flag;

    assign op = s_tdata[1:0];
    assign row = s_tdata[3:2];
    assign col = s_tdata[6:4];
    assign value = s_tdata[38:7];
    assign s_tready = idle;
    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) iter_reg <= 8'd30;
        else if (cfg_we) iter_reg <= cfg_wdata;
    end

    jls_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(acc && op == OP_START),
        .iteration_count(iter_reg), .stat(stat), .m_ready(m_tready), .cmd(cmd),
        .j_idx(j_idx), .k_idx(k_idx), .idle(idle), .emit_valid(m_tvalid),
        .emit_row(emit_row)
    );

    jls_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .load_coef(acc && op == OP_LOAD_COEF && col < COL_W'(N_COLS)),
        .load_guess(acc && op == OP_LOAD_GUESS), .ld_row(row), .ld_col(col),
        .ld_value(value), .cmd(cmd), .j_idx(j_idx), .k_idx(k_idx), .rd_idx(emit_row),
        .stat(stat), .rd_value(rd_value), .dz_flag(dz_flag)
    );

    assign m_tdata = {6'd0, rd_value, emit_row};
    assign m_tlast = (emit_row == ROW_W'(N_ROWS - 1));
    assign m_tuser = dz_flag;
endmodule

// ===== rtl/jls_divider.sv =====
// Restoring divider: signed numerator times 2^FRAC_BITS over signed divisor, saturating
module jls_divider import jls_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [NUM_W-1:0]      num,
    input  logic signed [DATA_WIDTH-1:0] den,
    output logic                         busy,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quot,
    output logic                         dz
);
    `include "jacobi_linear_solver_defines.svh"
    localparam logic [DIV_W-1:0] LIM_POS = DIV_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] LIM_NEG = DIV_W'(64'd1 << (DATA_WIDTH - 1));
    localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DIV_W-1:0]  rem_reg, rem_next, q_reg, q_next, dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] ud_reg, ud_next;
    logic              neg_reg, neg_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic signed [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic              dz_reg, dz_next;
    logic [DIV_W-1:0]  un, rsh, qn;
    logic [DIV_W-1:0]  lim;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next = rem_reg;
        q_next = q_reg;
        dvd_next = dvd_reg;
        ud_next = ud_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        quot_next = quot_reg;
        dz_next = 1'b0;
        un = num[NUM_W-1] ? DIV_W'(-num) : DIV_W'(num);
        lim = neg_reg ? LIM_NEG : LIM_POS;
        rsh = {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
        qn = {q_reg[DIV_W-2:0], 1'b0};
        if (start) begin
            if (den == '0) begin
                done_next = 1'b1;
                dz_next = 1'b1;
                quot_next = (num == '0) ? '0 : (num[NUM_W-1] ? VMIN : VMAX);
            end else begin
                busy_next = 1'b1;
                neg_next = num[NUM_W-1] ^ den[DATA_WIDTH-1];
                ud_next = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);
                dvd_next = un << FRAC_BITS;
                rem_next = '0;
                q_next = '0;
                cnt_next = DCNT_W'(DIV_W);
            end
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (q_reg > lim) quot_next = neg_reg ? VMIN : VMAX;
                else if (neg_reg) quot_next = DATA_WIDTH'(-q_reg);
                else quot_next = DATA_WIDTH'(q_reg);
            end else begin
                // one quotient bit per cycle
                if (rsh >= DIV_W'(ud_reg)) begin
                    rem_next = rsh - DIV_W'(ud_reg);
                    q_next = qn | DIV_W'(1);
                end else begin
                    rem_next = rsh;
                    q_next = qn;
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dz_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dz_reg <= dz_next;
        end
        rem_reg <= rem_next;
        q_reg <= q_next;
        dvd_reg <= dvd_next;
        ud_reg <= ud_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign dz = dz_reg;

    `JLS_ASSERT_NEXT(a_div_zero_done, aclk, aresetn, start && den == '0, done && !busy,
        "zero divisor must finish at once")
    `JLS_ASSERT_IMP(a_div_dz_done, aclk, aresetn, dz, done, "dz without done")
endmodule

// ===== rtl/jls_datapath.sv =====
// Solver datapath: coefficient store, guess registers, multiply-accumulate and divider
module jls_datapath import jls_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load_coef,
    input  logic                         load_guess,
    input  logic [ROW_W-1:0]             ld_row,
    input  logic [COL_W-1:0]             ld_col,
    input  logic signed [DATA_WIDTH-1:0] ld_value,
    input  dp_cmd_t                      cmd,
    input  logic [ROW_W-1:0]             j_idx,
    input  logic [ROW_W-1:0]             k_idx,
    input  logic [ROW_W-1:0]             rd_idx,
    output dp_stat_t                     stat,
    output logic signed [DATA_WIDTH-1:0] rd_value,
    output logic                         dz_flag
);
    logic signed [DATA_WIDTH-1:0] coef_mem [N_ROWS][N_COLS];
    logic signed [DATA_WIDTH-1:0] guess_reg [N_ROWS];
    logic signed [DATA_WIDTH-1:0] next_reg [N_ROWS];
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic                         prod_vld_reg;
    logic                         dz_reg, dz_next;
    logic signed [NUM_W-1:0]      num;
    logic signed [DATA_WIDTH-1:0] quot;
    logic                         div_dz;

    always_ff @(posedge aclk) begin
        if (load_coef) coef_mem[ld_row][ld_col] <= ld_value;
    end

    // floor shift is an arithmetic shift
    always_comb begin
        acc_next = acc_reg;
        if (cmd.clr_acc) acc_next = '0;
        else if (prod_vld_reg) acc_next = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
        dz_next = dz_reg;
        if (cmd.clr_dz) dz_next = 1'b0;
        else if (div_dz) dz_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            dz_reg <= 1'b0;
            for (int i = 0; i < N_ROWS; i++) guess_reg[i] <= '0;
        end else begin
            prod_vld_reg <= cmd.mac && (k_idx != j_idx);
            dz_reg <= dz_next;
            if (load_guess) guess_reg[ld_row] <= ld_value;
            else if (cmd.commit)
                for (int i = 0; i < N_ROWS; i++) guess_reg[i] <= next_reg[i];
        end
        prod_reg <= coef_mem[j_idx][k_idx] * guess_reg[k_idx];
        acc_reg <= acc_next;
        if (cmd.store_next) next_reg[j_idx] <= quot;
    end

    assign num = NUM_W'(coef_mem[j_idx][N_ROWS]) - NUM_W'(acc_reg);

    jls_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .num(num),
        .den(coef_mem[j_idx][j_idx]), .busy(stat.div_busy), .done(stat.div_done),
        .quot(quot), .dz(div_dz)
    );

    assign rd_value = guess_reg[rd_idx];
    assign dz_flag = dz_reg;
endmodule

// ===== rtl/jls_controller.sv =====
// Solver sequencer: sweep, row and column counters and output handshake
module jls_controller import jls_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [7:0]       iteration_count,
    input  dp_stat_t         stat,
    input  logic             m_ready,
    output dp_cmd_t          cmd,
    output logic [ROW_W-1:0] j_idx,
    output logic [ROW_W-1:0] k_idx,
    output logic             idle,
    output logic             emit_valid,
    output logic [ROW_W-1:0] emit_row
);
    `include "jacobi_linear_solver_defines.svh"
    state_t state_reg, state_next;
    logic [ROW_W-1:0] j_reg, j_next, k_reg, k_next;
    logic [7:0] sweep_reg, sweep_next;
    logic [1:0] drain_reg, drain_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg <= '0;
            k_reg <= '0;
            sweep_reg <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            j_reg <= j_next;
            k_reg <= k_next;
            sweep_reg <= sweep_next;
            drain_reg <= drain_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        j_next = j_reg;
        k_next = k_reg;
        sweep_next = sweep_reg;
        drain_next = drain_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.clr_dz = 1'b1;
                    cmd.clr_acc = 1'b1;
                    j_next = '0;
                    k_next = '0;
                    sweep_next = '0;
                    state_next = (iteration_count == 8'd0) ? ST_EMIT : ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == ROW_W'(N_ROWS - 1)) begin
                    drain_next = 2'd2;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                // let the product pipeline drain
                if (drain_reg != 2'd0) drain_next = drain_reg - 1'b1;
                else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.store_next = 1'b1;
                    cmd.clr_acc = 1'b1;
                    k_next = '0;
                    if (j_reg == ROW_W'(N_ROWS - 1)) state_next = ST_COMMIT;
                    else begin
                        j_next = j_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                j_next = '0;
                sweep_next = sweep_reg + 1'b1;
                state_next = (sweep_reg + 8'd1 == iteration_count) ? ST_EMIT : ST_MAC;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == ROW_W'(N_ROWS - 1)) begin
                        j_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign j_idx = j_reg;
    assign k_idx = k_reg;
    assign idle = (state_reg == ST_IDLE);
    assign emit_valid = (state_reg == ST_EMIT);
    assign emit_row = j_reg;

    `JLS_ASSERT_IMP(a_start_idle, aclk, aresetn, cmd.div_start, !stat.div_busy,
        "divider started while busy")
    `JLS_ASSERT_IMP(a_commit_row, aclk, aresetn, cmd.commit, j_reg == ROW_W'(N_ROWS - 1),
        "commit before last row")
endmodule
